// ----- rtl/core/sit_pkg.sv -----
// sit_pkg: shared codes for the sorted insert table
// command and status encodings used by the top level and the cells
// no dependencies
`default_nettype none

package sit_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int STATUS_W = 2;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // per-beat selection sent to every cell of the chain
  typedef struct packed {
    logic ins_en;   // shift the chain this cycle
    logic ins_sel;  // an insert that will land: mark the landing cell
    logic rd_sel;   // a read: the addressed cell shows its entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sit_if.sv -----
// sit_if: valid/ready channel interfaces of the sorted insert table
// command channel and result channel; depends on sit_pkg
`default_nettype none

interface sit_in_if
  import sit_pkg::*;
#(
  parameter int KEY_W = 32,
  parameter int PAY_W = 16,
  parameter int IDX_W = 10
);
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] sort_key;
  logic [PAY_W-1:0] payload;
  logic [IDX_W-1:0] read_index;

  modport source (output valid, cmd, sort_key, payload, read_index, input ready);
  modport sink   (input valid, cmd, sort_key, payload, read_index, output ready);
endinterface

interface sit_out_if
  import sit_pkg::*;
#(
  parameter int KEY_W = 32,
  parameter int PAY_W = 16,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot;
  logic [KEY_W-1:0] key_out;
  logic [PAY_W-1:0] payload_out;
  logic [CNT_W-1:0] entry_count;
  status_t          status;

  modport source (output valid, slot, key_out, payload_out, entry_count, status,
                  input ready);
  modport sink   (input valid, slot, key_out, payload_out, entry_count, status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sit_cell.sv -----
// sit_cell: one slot of the sorted chain, holds a key and a payload
// compares against the new key, shifts from its lower neighbor; depends on sit_pkg
`default_nettype none

module sit_cell
  import sit_pkg::*;
#(
  parameter int KEY_W = 32,
  parameter int PAY_W = 16,
  parameter int IDX_W = 10,
  parameter int CNT_W = 11,
  parameter int INDEX = 0
) (
  input  wire logic                         clk,
  input  wire cell_ctl_t                    ctl,
  input  wire logic [CNT_W-1:0]             count,
  input  wire logic [KEY_W-1:0]             new_key,
  input  wire logic [PAY_W-1:0]             new_pay,
  input  wire logic [IDX_W-1:0]             ridx,
  input  wire logic                         prev_ge,
  input  wire logic [KEY_W-1:0]             prev_key,
  input  wire logic [PAY_W-1:0]             prev_pay,
  output logic                              ge,
  output logic [KEY_W-1:0]                  key_q,
  output logic [PAY_W-1:0]                  pay_q,
  output logic [IDX_W+KEY_W+PAY_W-1:0]      leaf
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic             occupied;
  logic             land;

  // cells past the fill level count as greater, so the chain stays monotone
  assign occupied = MY_CNT < count;
  assign ge       = !occupied || (key_r > new_key);
  assign land     = ge && !prev_ge;

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (prev_ge) begin
        key_r <= prev_key;
        pay_r <= prev_pay;
      end else if (ge) begin
        key_r <= new_key;
        pay_r <= new_pay;
      end
    end
  end

  always_comb begin
    leaf = '0;
    if (ctl.rd_sel) begin
      if (occupied && (ridx == MY_IDX)) begin
        leaf = {MY_IDX, key_r, pay_r};
      end
    end else if (ctl.ins_sel && land) begin
      leaf = {MY_IDX, {(KEY_W+PAY_W){1'b0}}};
    end
  end

  assign key_q = key_r;
  assign pay_q = pay_r;

endmodule

`default_nettype wire

// ----- rtl/core/sit_or_tree.sv -----
// sit_or_tree: registered or-reduction tree that collects the one selected cell
// one register level per tree level; no dependencies
`default_nettype none

module sit_or_tree #(
  parameter int N = 1024,
  parameter int W = 58
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] leaf [N],
  output logic [W-1:0]      root
);

  localparam int LV = $clog2(N);
  localparam int P  = 1 << LV;

  logic [W-1:0] leaf_w [P];
  logic [W-1:0] node_r [1:P-1];

  genvar i, n;
  generate
    for (i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_used
        assign leaf_w[i] = leaf[i];
      end else begin : g_pad
        assign leaf_w[i] = '0;
      end
    end

    // heap order: node n has children 2n and 2n+1, leaves sit at P and up
    for (n = 1; n < P; n++) begin : g_node
      if (2 * n >= P) begin : g_bottom
        always_ff @(posedge clk) begin
          node_r[n] <= leaf_w[2*n-P] | leaf_w[2*n+1-P];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node_r[n] <= node_r[2*n] | node_r[2*n+1];
        end
      end
    end
  endgenerate

  assign root = node_r[1];

endmodule

`default_nettype wire

// ----- rtl/core/sorted_insert_table.sv -----
// sorted_insert_table: table kept in ascending key order in a chain of cells
// an insert or read is accepted when the input is ready; its result passes through
// the registered or-tree that gathers the slot, then a hold and an output register
// input is not ready until the previous result has left the hold register, so a
// new beat waits on the output; input is not ready while reset is held
// reset clears the fill count and handshake state; cell contents are not reset
`default_nettype none

module sorted_insert_table
  import sit_pkg::*;
#(
  parameter int TABLE_DEPTH  = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sit_in_if.sink    in_bus,
  sit_out_if.source out_bus
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LV    = $clog2(TABLE_DEPTH);
  localparam int WT_W  = $clog2(LV + 1);
  localparam int LEAF_W = IDX_W + KEY_BITS + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [WT_W-1:0]  LV_WT     = WT_W'(LV);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [WT_W-1:0]         wait_r, wait_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    rd_r;
  logic [IDX_W-1:0]        ridx_r;
  logic [CNT_W-1:0]        cnt_snap_r;
  status_t                 status_r;

  logic [IDX_W-1:0]        hold_slot_r;
  logic [KEY_BITS-1:0]     hold_key_r;
  logic [PAYLOAD_BITS-1:0] hold_pay_r;
  logic [CNT_W-1:0]        hold_cnt_r;
  status_t                 hold_status_r;

  logic [IDX_W-1:0]        out_slot_r;
  logic [KEY_BITS-1:0]     out_key_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [CNT_W-1:0]        out_cnt_r;
  status_t                 out_status_r;

  logic       accept, is_read, full, busy, capture, out_free, move_out;
  cell_ctl_t  ctl;
  status_t    status_now;

  logic                    ge    [TABLE_DEPTH];
  logic [KEY_BITS-1:0]     key_q [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_q [TABLE_DEPTH];
  logic [LEAF_W-1:0]       leaf  [TABLE_DEPTH];
  logic [LEAF_W-1:0]       root;

  assign busy         = (wait_r != '0) || pend_r;
  assign in_bus.ready = rst_n && !busy;
  assign accept       = in_bus.valid && in_bus.ready;
  assign is_read      = in_bus.cmd == CMD_READ;
  assign full         = count_r >= DEPTH_CNT;

  assign ctl.ins_en  = accept && !is_read && !full;
  assign ctl.ins_sel = !is_read && !full;
  assign ctl.rd_sel  = is_read;

  always_comb begin
    status_now = ST_OK;
    if (is_read) begin
      if (CNT_W'(in_bus.read_index) >= count_r) status_now = ST_EMPTY;
    end else if (full) begin
      status_now = ST_FULL;
    end
  end

  genvar c;
  generate
    for (c = 0; c < TABLE_DEPTH; c++) begin : g_cell
      if (c == 0) begin : g_head
        sit_cell #(
          .KEY_W(KEY_BITS), .PAY_W(PAYLOAD_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W),
          .INDEX(c)
        ) u_cell (
          .clk(clk), .ctl(ctl), .count(count_r),
          .new_key(in_bus.sort_key), .new_pay(in_bus.payload),
          .ridx(in_bus.read_index),
          .prev_ge(1'b0), .prev_key('0), .prev_pay('0),
          .ge(ge[c]), .key_q(key_q[c]), .pay_q(pay_q[c]), .leaf(leaf[c])
        );
      end else begin : g_body
        sit_cell #(
          .KEY_W(KEY_BITS), .PAY_W(PAYLOAD_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W),
          .INDEX(c)
        ) u_cell (
          .clk(clk), .ctl(ctl), .count(count_r),
          .new_key(in_bus.sort_key), .new_pay(in_bus.payload),
          .ridx(in_bus.read_index),
          .prev_ge(ge[c-1]), .prev_key(key_q[c-1]), .prev_pay(pay_q[c-1]),
          .ge(ge[c]), .key_q(key_q[c]), .pay_q(pay_q[c]), .leaf(leaf[c])
        );
      end
    end
  endgenerate

  // the leaves of the accept cycle reach the root through the tree's register levels
  sit_or_tree #(.N(TABLE_DEPTH), .W(LEAF_W)) u_tree (
    .clk(clk), .leaf(leaf), .root(root)
  );

  assign capture  = wait_r == WT_W'(1);
  assign out_free = !out_valid_r || out_bus.ready;
  assign move_out = pend_r && out_free;

  always_comb begin
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (ctl.ins_en) count_nxt = count_r + CNT_W'(1);
    if (accept) begin
      wait_nxt = LV_WT;
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - WT_W'(1);
    end
    if (capture) begin
      pend_nxt = 1'b1;
    end else if (move_out) begin
      pend_nxt = 1'b0;
    end
    if (move_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wait_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= is_read;
      ridx_r     <= in_bus.read_index;
      cnt_snap_r <= count_nxt;
      status_r   <= status_now;
    end
    if (capture) begin
      hold_slot_r   <= rd_r ? ridx_r : root[LEAF_W-1 -: IDX_W];
      hold_key_r    <= root[PAYLOAD_BITS +: KEY_BITS];
      hold_pay_r    <= root[PAYLOAD_BITS-1:0];
      hold_cnt_r    <= cnt_snap_r;
      hold_status_r <= status_r;
    end
    if (move_out) begin
      out_slot_r   <= hold_slot_r;
      out_key_r    <= hold_key_r;
      out_pay_r    <= hold_pay_r;
      out_cnt_r    <= hold_cnt_r;
      out_status_r <= hold_status_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.slot        = out_slot_r;
  assign out_bus.key_out     = out_key_r;
  assign out_bus.payload_out = out_pay_r;
  assign out_bus.entry_count = out_cnt_r;
  assign out_bus.status      = out_status_r;

endmodule

`default_nettype wire
